// File: design/vfc_pkg.sv
`default_nettype none

package vfc_pkg;

    localparam int MAX_VERTEX_WORDS = 32;
    localparam int MAX_TEXTURE_SETS = 8;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 5;
    localparam int POS_W   = 7;
    localparam int CFG_W   = 3;
    localparam int CFG_D_W = 4;

    localparam logic [WORD_W-1:0] WHITE_WORD = 32'hffffffff;

    localparam logic [CFG_W-1:0] CFG_POSITION_CLASS = 3'd0;
    localparam logic [CFG_W-1:0] CFG_SOURCE_FLAGS   = 3'd1;
    localparam logic [CFG_W-1:0] CFG_DEST_FLAGS     = 3'd2;
    localparam logic [CFG_W-1:0] CFG_SOURCE_SETS    = 3'd3;
    localparam logic [CFG_W-1:0] CFG_DEST_SETS      = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0] source_word;
        logic              last_vertex_in_batch;
    } vfc_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] dest_word;
        logic              end_of_vertex;
        logic              end_of_batch;
        logic              format_error;
    } vfc_out_t;

    typedef enum logic [2:0] {
        OP_CHECK,
        OP_POS,
        OP_ATTR,
        OP_TEX,
        OP_HALT
    } vfc_op_t;

    typedef enum logic [1:0] {
        SEL_MEM,
        SEL_ZERO,
        SEL_WHITE
    } vfc_sel_t;

    typedef struct packed {
        vfc_op_t    op;
        logic [1:0] flag_bit;
        logic [1:0] width;
        vfc_sel_t   fill;
    } vfc_ucode_t;

    typedef struct packed {
        vfc_sel_t         sel;
        logic             end_of_vertex;
        logic             end_of_batch;
        logic             format_error;
    } vfc_req_t;

    // conversion program, one control word per field group
    function automatic vfc_ucode_t ucode(input logic [2:0] step);
        vfc_ucode_t cw;
        case (step)
            3'd0:    cw = '{op: OP_CHECK, flag_bit: 2'd0, width: 2'd0, fill: SEL_ZERO};
            3'd1:    cw = '{op: OP_POS,   flag_bit: 2'd0, width: 2'd0, fill: SEL_ZERO};
            3'd2:    cw = '{op: OP_ATTR,  flag_bit: 2'd0, width: 2'd1, fill: SEL_ZERO};
            3'd3:    cw = '{op: OP_ATTR,  flag_bit: 2'd1, width: 2'd3, fill: SEL_ZERO};
            3'd4:    cw = '{op: OP_ATTR,  flag_bit: 2'd2, width: 2'd1, fill: SEL_WHITE};
            3'd5:    cw = '{op: OP_ATTR,  flag_bit: 2'd3, width: 2'd1, fill: SEL_WHITE};
            3'd6:    cw = '{op: OP_TEX,   flag_bit: 2'd0, width: 2'd0, fill: SEL_ZERO};
            default: cw = '{op: OP_HALT,  flag_bit: 2'd0, width: 2'd0, fill: SEL_ZERO};
        endcase
        return cw;
    endfunction

    function automatic logic [3:0] pos_words(input logic [2:0] pc);
        logic [3:0] n;
        case (pc)
            3'd0:    n = 4'd0;
            3'd1:    n = 4'd3;
            3'd2:    n = 4'd4;
            3'd3:    n = 4'd4;
            3'd4:    n = 4'd5;
            3'd5:    n = 4'd6;
            3'd6:    n = 4'd7;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] sat_sets(input logic [3:0] n);
        return (n > 4'(MAX_TEXTURE_SETS)) ? 4'(MAX_TEXTURE_SETS) : n;
    endfunction

    // sets must already be saturated
    function automatic logic [COUNT_W-1:0] layout_size(input logic [2:0] pc,
                                                       input logic [3:0] flags,
                                                       input logic [3:0] sets);
        logic [COUNT_W-1:0] n;
        n = COUNT_W'(pos_words(pc)) + COUNT_W'(flags[0]) + (flags[1] ? 5'd3 : 5'd0)
            + COUNT_W'(flags[2]) + COUNT_W'(flags[3]) + {sets, 1'b0};
        return n;
    endfunction

endpackage

`default_nettype wire

// File: design/vfc_ram.sv
`default_nettype none

module vfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/vertex_format_converter_unit.sv
// source words: one per cycle while collecting; stalled while a vertex is converted
// conversion: a program of 8 steps emits the destination words in turn, only a format error word on error
// read port and output register overlap: one word per cycle within a field group unless dst_stall holds it,
// with a step change that emits nothing between groups
// reset: format registers to defaults, word count cleared, no buffer clearing pass
`default_nettype none

module vertex_format_converter_unit #(
    parameter int MAX_VERTEX_WORDS = vfc_pkg::MAX_VERTEX_WORDS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          src_valid,
    output logic                               src_stall,
    input  wire vfc_pkg::vfc_in_t              src_data,
    output logic                               dst_valid,
    input  wire logic                          dst_stall,
    output vfc_pkg::vfc_out_t                  dst_data,
    input  wire logic                          cfg_we,
    input  wire logic [vfc_pkg::CFG_W-1:0]     cfg_index,
    input  wire logic [vfc_pkg::CFG_D_W-1:0]   cfg_data
);

    localparam int ADDR_W   = $clog2(MAX_VERTEX_WORDS);
    localparam int POS_W    = vfc_pkg::POS_W;
    localparam int CNT_W    = vfc_pkg::COUNT_W;
    localparam int WORD_W_L = vfc_pkg::WORD_W;

    // format registers
    logic [2:0] pos_class_reg, pos_class_next;
    logic [3:0] src_flags_reg, src_flags_next;
    logic [3:0] dst_flags_reg, dst_flags_next;
    logic [3:0] src_sets_reg, src_sets_next;
    logic [3:0] dst_sets_reg, dst_sets_next;

    // collect side
    logic [CNT_W-1:0] word_count_reg, word_count_next;
    logic             last_reg, last_next;

    // sequencer
    logic             busy_reg, busy_next;
    logic [2:0]       step_reg, step_next;
    logic [CNT_W-1:0] rep_reg, rep_next;
    logic [POS_W-1:0] src_ptr_reg, src_ptr_next;
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;

    // read stage and output register
    logic              pend_valid_reg, pend_valid_next;
    vfc_pkg::vfc_req_t pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    vfc_pkg::vfc_out_t out_reg, out_next;

    logic [3:0]        src_sets, dst_sets;
    logic [CNT_W-1:0]  src_size, dst_size;
    logic              fmt_err;
    logic              src_accept;
    logic [CNT_W:0]    idx_inc;
    logic              vertex_done;
    logic              ram_we;
    logic [WORD_W_L-1:0] ram_rdata;
    logic [POS_W-1:0]  rd_pos;
    logic [ADDR_W-1:0] rd_addr;
    logic              advance;
    logic              out_free;
    logic              emit;
    logic [CNT_W-1:0]  step_len;
    vfc_pkg::vfc_ucode_t cw;
    vfc_pkg::vfc_req_t req;
    logic              src_has, dst_has;
    logic [3:0]        set_i;
    logic [POS_W-1:0]  tex_base;

    assign src_sets = vfc_pkg::sat_sets(src_sets_reg);
    assign dst_sets = vfc_pkg::sat_sets(dst_sets_reg);
    assign src_size = vfc_pkg::layout_size(pos_class_reg, src_flags_reg, src_sets);
    assign dst_size = vfc_pkg::layout_size(pos_class_reg, dst_flags_reg, dst_sets);
    assign fmt_err  = (dst_flags_reg[1] && !src_flags_reg[1])
                   || ((dst_sets > src_sets) && (src_sets == 4'd0));

    assign src_stall  = busy_reg;
    assign src_accept = src_valid && !busy_reg;
    assign idx_inc    = {1'b0, word_count_reg} + (CNT_W+1)'(1);
    // an empty source layout still takes one word
    assign vertex_done = (src_size == '0) ? 1'b1 : (idx_inc >= {1'b0, src_size});
    assign ram_we = src_accept
                 && ((POS_W'(word_count_reg)) < POS_W'(MAX_VERTEX_WORDS));

    assign out_free = !out_valid_reg || !dst_stall;
    assign advance  = !pend_valid_reg || out_free;

    assign cw      = vfc_pkg::ucode(step_reg);
    assign src_has = src_flags_reg[cw.flag_bit];
    assign dst_has = dst_flags_reg[cw.flag_bit];
    assign set_i   = rep_reg[CNT_W-1:1];
    assign tex_base = (set_i < src_sets) ? src_ptr_reg + POS_W'({set_i, 1'b0}) : src_ptr_reg;

    always_comb
    begin
        case (cw.op)
            vfc_pkg::OP_CHECK: step_len = fmt_err ? CNT_W'(1) : '0;
            vfc_pkg::OP_POS:   step_len = CNT_W'(vfc_pkg::pos_words(pos_class_reg));
            vfc_pkg::OP_ATTR:  step_len = dst_has ? CNT_W'(cw.width) : '0;
            vfc_pkg::OP_TEX:   step_len = {dst_sets, 1'b0};
            default:           step_len = '0;
        endcase

        case (cw.op)
            vfc_pkg::OP_ATTR: rd_pos = src_ptr_reg + POS_W'(rep_reg);
            vfc_pkg::OP_TEX:  rd_pos = tex_base + POS_W'(rep_reg[0]);
            default:          rd_pos = POS_W'(rep_reg);
        endcase

        emit = busy_reg && (rep_reg < step_len);

        req.format_error  = (cw.op == vfc_pkg::OP_CHECK);
        req.end_of_vertex = req.format_error || ((emit_cnt_reg + CNT_W'(1)) == dst_size);
        req.end_of_batch  = req.end_of_vertex && last_reg;
        if (cw.op == vfc_pkg::OP_CHECK)
        begin
            req.sel = vfc_pkg::SEL_ZERO;
        end
        else if ((cw.op == vfc_pkg::OP_ATTR) && !src_has)
        begin
            req.sel = cw.fill;
        end
        else if (rd_pos < POS_W'(MAX_VERTEX_WORDS))
        begin
            req.sel = vfc_pkg::SEL_MEM;
        end
        else
        begin
            req.sel = vfc_pkg::SEL_ZERO;
        end
    end

    assign rd_addr = ADDR_W'(rd_pos);

    vfc_ram #(
        .WIDTH (WORD_W_L),
        .DEPTH (MAX_VERTEX_WORDS)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(word_count_reg)),
        .wdata (src_data.source_word),
        .re    (advance),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        pos_class_next = pos_class_reg;
        src_flags_next = src_flags_reg;
        dst_flags_next = dst_flags_reg;
        src_sets_next  = src_sets_reg;
        dst_sets_next  = dst_sets_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                vfc_pkg::CFG_POSITION_CLASS: pos_class_next = cfg_data[2:0];
                vfc_pkg::CFG_SOURCE_FLAGS:   src_flags_next = cfg_data;
                vfc_pkg::CFG_DEST_FLAGS:     dst_flags_next = cfg_data;
                vfc_pkg::CFG_SOURCE_SETS:    src_sets_next  = cfg_data;
                vfc_pkg::CFG_DEST_SETS:      dst_sets_next  = cfg_data;
                default:                     ;
            endcase
        end

        word_count_next = word_count_reg;
        last_next       = last_reg;
        busy_next       = busy_reg;
        step_next       = step_reg;
        rep_next        = rep_reg;
        src_ptr_next    = src_ptr_reg;
        emit_cnt_next   = emit_cnt_reg;

        if (src_accept)
        begin
            if (vertex_done)
            begin
                word_count_next = '0;
                last_next       = src_data.last_vertex_in_batch;
                busy_next       = 1'b1;
                step_next       = '0;
                rep_next        = '0;
                src_ptr_next    = '0;
                emit_cnt_next   = '0;
            end
            else
            begin
                word_count_next = idx_inc[CNT_W-1:0];
            end
        end
        else if (busy_reg && advance)
        begin
            if (emit)
            begin
                rep_next      = rep_reg + CNT_W'(1);
                emit_cnt_next = emit_cnt_reg + CNT_W'(1);
            end
            else if ((cw.op == vfc_pkg::OP_HALT)
                  || ((cw.op == vfc_pkg::OP_CHECK) && fmt_err))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                // step finished: move past the source words of this field group
                step_next = step_reg + 3'd1;
                rep_next  = '0;
                case (cw.op)
                    vfc_pkg::OP_POS:
                        src_ptr_next = POS_W'(vfc_pkg::pos_words(pos_class_reg));
                    vfc_pkg::OP_ATTR:
                        src_ptr_next = src_has ? src_ptr_reg + POS_W'(cw.width) : src_ptr_reg;
                    default:
                        src_ptr_next = src_ptr_reg;
                endcase
            end
        end

        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (advance)
        begin
            pend_valid_next = emit;
            pend_next       = req;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_free)
        begin
            out_valid_next = pend_valid_reg;
            if (pend_valid_reg)
            begin
                case (pend_reg.sel)
                    vfc_pkg::SEL_MEM:   out_next.dest_word = ram_rdata;
                    vfc_pkg::SEL_WHITE: out_next.dest_word = vfc_pkg::WHITE_WORD;
                    default:            out_next.dest_word = '0;
                endcase
                out_next.end_of_vertex = pend_reg.end_of_vertex;
                out_next.end_of_batch  = pend_reg.end_of_batch;
                out_next.format_error  = pend_reg.format_error;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_class_reg  <= 3'd1;
            src_flags_reg  <= '0;
            dst_flags_reg  <= '0;
            src_sets_reg   <= '0;
            dst_sets_reg   <= '0;
            word_count_reg <= '0;
            busy_reg       <= 1'b0;
            step_reg       <= '0;
            rep_reg        <= '0;
            emit_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_class_reg  <= pos_class_next;
            src_flags_reg  <= src_flags_next;
            dst_flags_reg  <= dst_flags_next;
            src_sets_reg   <= src_sets_next;
            dst_sets_reg   <= dst_sets_next;
            word_count_reg <= word_count_next;
            busy_reg       <= busy_next;
            step_reg       <= step_next;
            rep_reg        <= rep_next;
            emit_cnt_reg   <= emit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg    <= last_next;
        src_ptr_reg <= src_ptr_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    assign dst_valid = out_valid_reg;
    assign dst_data  = out_reg;

endmodule

`default_nettype wire
